// ----- hw/rtl/csec_pkg.sv -----
// Shared types, constants and fixed-point helpers for the Chebyshev series evaluator.
package csec_pkg;

  // Default highest Chebyshev index held in the coefficient table
  localparam int DEG_LIMIT_DEF = 63;

  // Field widths fixed by the interface
  localparam int IDX_W     = 6;
  localparam int DEG_W     = 6;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_RE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_IM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 2'd3;

  // Input word actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  typedef logic signed [31:0] q16_t;   // Q16.16 value
  typedef logic signed [63:0] prod_t;  // exact product of two Q16.16 values
  typedef logic signed [47:0] qprod_t; // product rounded back to Q16.16 scale

  // Saturated value plus its overflow flag
  typedef struct packed {
    logic ovf;
    q16_t val;
  } sat_t;

  localparam q16_t           Q_ONE      = 32'sd65536;
  localparam q16_t           CENTER_RST = 32'sd0;
  localparam q16_t           INV_RE_RST = Q_ONE;
  localparam q16_t           INV_IM_RST = 32'sd0;
  localparam logic [DEG_W-1:0] DEGREE_RST = 6'd1;

  // Round a Q32.32 product to Q32.16 (Q16.16 scale), nearest with ties toward plus infinity
  function automatic qprod_t qround(input prod_t p);
    return $signed(p[63:16]) + $signed({47'd0, p[15]});
  endfunction

  // Clamp to the signed 32-bit range and flag when clamping happened
  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t s;
    if (v > 64'sd2147483647) begin
      s.ovf = 1'b1;
      s.val = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      s.ovf = 1'b1;
      s.val = 32'sh80000000;
    end else begin
      s.ovf = 1'b0;
      s.val = v[31:0];
    end
    return s;
  endfunction

endpackage

// ----- hw/rtl/chebyshev_series_eval_complex_unit.sv -----
// Evaluate item: busy through terms 0 to D (D = clamped degree), result strobe
// in the next cycle; a new word can be taken at the end of that cycle.
// Per term (the first skips the recurrence), two shared 32x32 multipliers run the complex
// recurrence product, then the coefficient product, with one coefficient table read per term.
// Write item: busy stays low. Results cannot be stalled by the receiver.
// Synchronous active-low reset clears sequencer, strobe and config; the coefficient table is not.
module chebyshev_series_eval_complex_unit #(
  parameter int DEG_LIMIT = csec_pkg::DEG_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [csec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_action,
  input  logic [csec_pkg::IDX_W-1:0]     in_coef_index,
  input  logic signed [31:0]             in_coef_value,
  input  logic signed [31:0]             in_x_re,
  input  logic signed [31:0]             in_x_im,
  output logic                           out_valid,
  output logic signed [31:0]             out_result_re,
  output logic signed [31:0]             out_result_im,
  output logic                           out_overflow
);
  import csec_pkg::*;

  localparam int DEPTH  = DEG_LIMIT + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  // 2*qround is at most 2^47 in magnitude per term; room for DEPTH terms plus sign
  localparam int ACC_W  = 49 + ADDR_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_T0,
    S_T1,
    S_T2,
    S_REC_RE,
    S_REC_IM,
    S_COEF,
    S_ACC,
    S_FIN
  } state_t;

  state_t state_r;

  // Configuration
  q16_t             center_r, inv_re_r, inv_im_r;
  logic [DEG_W-1:0] degree_r;

  // Datapath registers
  q16_t                    dr_r, di_r, tr_r, ti_r;
  q16_t                    ar_r, ai_r, br_r, bi_r, nr_r;
  logic [ADDR_W-1:0]       k_r, deg_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic                    ovf_r;
  prod_t                   prod0_r, prod1_r;

  // Result registers
  logic out_valid_r, out_overflow_r;
  q16_t out_re_r, out_im_r;

  // Coefficient table
  q16_t              coef_mem [DEPTH];
  q16_t              coef_q_r;
  logic [ADDR_W-1:0] rd_addr, wr_addr, deg_clamp;
  logic              accept, wr_en;

  // Combinational helpers
  q16_t   mop0_a, mop0_b, mop1_a, mop1_b;
  qprod_t q0, q1;
  sat_t   d_sat, t_re_sat, t_im_sat, n_re_sat, n_im_sat, res_re_sat, res_im_sat;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (in_action == ACT_WRITE) &&
                  (32'(in_coef_index) <= 32'(DEG_LIMIT));
  assign wr_addr = ADDR_W'(in_coef_index);
  assign rd_addr = busy ? k_r : '0;

  assign deg_clamp = (32'(degree_r) > 32'(DEG_LIMIT)) ? ADDR_W'(DEG_LIMIT)
                                                      : ADDR_W'(degree_r);

  // Table write on accept, registered read every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      coef_mem[wr_addr] <= in_coef_value;
    end
    coef_q_r <= coef_mem[rd_addr];
  end

  // Multiplier operand selection per sequencer step
  always_comb begin
    case (state_r)
      S_T0: begin
        mop0_a = dr_r;     mop0_b = inv_re_r;
        mop1_a = di_r;     mop1_b = inv_im_r;
      end
      S_T1: begin
        mop0_a = dr_r;     mop0_b = inv_im_r;
        mop1_a = di_r;     mop1_b = inv_re_r;
      end
      S_REC_RE: begin
        mop0_a = tr_r;     mop0_b = bi_r;
        mop1_a = ti_r;     mop1_b = br_r;
      end
      S_COEF: begin
        mop0_a = coef_q_r; mop0_b = br_r;
        mop1_a = coef_q_r; mop1_b = bi_r;
      end
      default: begin
        mop0_a = tr_r;     mop0_b = br_r;
        mop1_a = ti_r;     mop1_b = bi_r;
      end
    endcase
  end

  // Two shared multipliers, registered
  always_ff @(posedge clk) begin
    prod0_r <= mop0_a * mop0_b;
    prod1_r <= mop1_a * mop1_b;
  end

  // Rounding, recombination and saturation
  assign q0 = qround(prod0_r);
  assign q1 = qround(prod1_r);

  assign d_sat      = sat32(64'(in_x_re) - 64'(center_r));
  assign t_re_sat   = sat32(64'(q0) - 64'(q1));
  assign t_im_sat   = sat32(64'(q0) + 64'(q1));
  assign n_re_sat   = sat32(((64'(q0) - 64'(q1)) <<< 1) - 64'(ar_r));
  assign n_im_sat   = sat32(((64'(q0) + 64'(q1)) <<< 1) - 64'(ai_r));
  assign res_re_sat = sat32(64'(acc_re_r));
  assign res_im_sat = sat32(64'(acc_im_r));

  // Sequencer, config registers and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      center_r    <= CENTER_RST;
      inv_re_r    <= INV_RE_RST;
      inv_im_r    <= INV_IM_RST;
      degree_r    <= DEGREE_RST;
    end else begin
      out_valid_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTER: center_r <= cfg_wdata;
          CFG_INV_RE: inv_re_r <= cfg_wdata;
          CFG_INV_IM: inv_im_r <= cfg_wdata;
          CFG_DEGREE: degree_r <= cfg_wdata[DEG_W-1:0];
          default:    ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (accept && (in_action == ACT_EVAL)) begin
            dr_r    <= d_sat.val;
            di_r    <= in_x_im;
            ovf_r   <= d_sat.ovf;
            k_r     <= ADDR_W'(1);
            deg_r   <= deg_clamp;
            state_r <= S_T0;
          end
        end
        // c0 arrives from the table; first half of t = d * scale starts
        S_T0: begin
          acc_re_r <= ACC_W'(coef_q_r);
          acc_im_r <= '0;
          state_r  <= S_T1;
        end
        S_T1: begin
          tr_r    <= t_re_sat.val;
          ovf_r   <= ovf_r | t_re_sat.ovf;
          state_r <= S_T2;
        end
        // T0 = 1, T1 = t
        S_T2: begin
          ti_r    <= t_im_sat.val;
          ovf_r   <= ovf_r | t_im_sat.ovf;
          ar_r    <= Q_ONE;
          ai_r    <= '0;
          br_r    <= tr_r;
          bi_r    <= t_im_sat.val;
          state_r <= (deg_r == '0) ? S_FIN : S_COEF;
        end
        // Real part of Tk = 2 t T(k-1) - T(k-2)
        S_REC_RE: begin
          nr_r    <= n_re_sat.val;
          ovf_r   <= ovf_r | n_re_sat.ovf;
          state_r <= S_REC_IM;
        end
        // Imaginary part, then shift the recurrence window
        S_REC_IM: begin
          ar_r    <= br_r;
          ai_r    <= bi_r;
          br_r    <= nr_r;
          bi_r    <= n_im_sat.val;
          ovf_r   <= ovf_r | n_im_sat.ovf;
          state_r <= S_COEF;
        end
        S_COEF: begin
          state_r <= S_ACC;
        end
        // Add 2*ck*Tk; multipliers already start the next term
        S_ACC: begin
          acc_re_r <= acc_re_r + (ACC_W'(q0) <<< 1);
          acc_im_r <= acc_im_r + (ACC_W'(q1) <<< 1);
          if (k_r == deg_r) begin
            state_r <= S_FIN;
          end else begin
            k_r     <= k_r + ADDR_W'(1);
            state_r <= S_REC_RE;
          end
        end
        S_FIN: begin
          out_re_r       <= res_re_sat.val;
          out_im_r       <= res_im_sat.val;
          out_overflow_r <= ovf_r | res_re_sat.ovf | res_im_sat.ovf;
          out_valid_r    <= 1'b1;
          state_r        <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result_re = out_re_r;
  assign out_result_im = out_im_r;
  assign out_overflow  = out_overflow_r;

endmodule

// ----- hw/rtl/csec_checker.sv -----
// Port-level checker for the Chebyshev series evaluator, bound to the top level.
module csec_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_action,
  input logic out_valid
);
  import csec_pkg::*;

  // Results are single-cycle strobes
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // A result only follows an evaluation in progress
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding evaluation");

  // An evaluate word starts work
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == ACT_EVAL)) |=> busy)
    else $error("evaluate word accepted but block not busy");

  // A coefficient write does not make the block busy
  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == ACT_WRITE)) |=> !busy)
    else $error("coefficient write kept the block busy");

  // End of an evaluation always delivers a word
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("evaluation ended without a result");

endmodule

bind chebyshev_series_eval_complex_unit csec_checker u_csec_checker (.*);
